### design/assert_macros.svh
// Assertion macros shared by the design files.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under an active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/lagr_pkg.sv
// Shared types, constants and modular helpers for the interpolation unit.
// No dependencies.
package lagr_pkg;

  localparam int unsigned MaxNodesDefault = 1024;
  localparam logic [29:0] Prime = 30'd998244353;
  // floor(2^60 / P), fits in 31 bits
  localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'(Prime));

  // Configuration register indexes
  localparam logic CfgNodeBase = 1'b0;
  localparam logic CfgDegree   = 1'b1;

  // Request kinds
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqEval = 1'b1;

  // Multiply operation codes (OpYPre to OpPre are also the step order within one node)
  localparam logic [2:0] OpYPre   = 3'd0;
  localparam logic [2:0] OpTSuf   = 3'd1;
  localparam logic [2:0] OpTInvK  = 3'd2;
  localparam logic [2:0] OpTInvDk = 3'd3;
  localparam logic [2:0] OpPre    = 3'd4;
  localparam logic [2:0] OpSuf    = 3'd5;

  typedef struct packed {
    logic        req_type;
    logic [29:0] sample_value;
    logic [29:0] eval_point;
  } req_t;

  typedef struct packed {
    logic [29:0] interp_value;
    logic        samples_short;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       eval_init;
    logic       mul_go;
    logic [2:0] op;
    logic       finish;
  } lagr_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_is_d;
    logic mul_done;
  } lagr_status_t;

  // Reduce a 30-bit value into 0..P-1
  function automatic logic [29:0] red30(input logic [29:0] v);
    logic [29:0] r;
    r = (v >= Prime) ? (v - Prime) : v;
    return r;
  endfunction

  // Elaboration-time modular helpers for the constant table
  function automatic longint unsigned mulm_c(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned r;
    r = (a * b) % Prime;
    return r;
  endfunction

  function automatic longint unsigned powm_c(input longint unsigned b0,
                                             input longint unsigned e0);
    longint unsigned r;
    longint unsigned b;
    longint unsigned e;
    r = 1;
    b = b0;
    e = e0;
    while (e != 0) begin
      if (e[0]) r = mulm_c(r, b);
      b = mulm_c(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

endpackage

### design/lagr_modmul.sv
// Four-stage pipelined Barrett modular multiplier, operands below P.
// Depends on lagr_pkg.
module lagr_modmul
  import lagr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [29:0] a_i,
  input  logic [29:0] b_i,
  output logic        done_o,
  output logic [29:0] res_o
);

  logic [3:0]  vld_q;
  logic [59:0] p1_q;
  logic [61:0] q2_q;
  logic [31:0] lo2_q;
  logic [31:0] r3_q;
  logic [29:0] res_q;
  logic [29:0] q3;
  logic [59:0] qp_full;

  // Advance the valid tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], go_i};
    end
  end

  assign q3      = q2_q[60:31];
  assign qp_full = {30'd0, q3} * {30'd0, Prime};

  // Product, quotient estimate, remainder, final correction
  always_ff @(posedge clk_i) begin
    p1_q  <= {30'd0, a_i} * {30'd0, b_i};
    q2_q  <= {31'd0, p1_q[59:29]} * {31'd0, BarrettMu};
    lo2_q <= p1_q[31:0];
    r3_q  <= lo2_q - qp_full[31:0];
    if (r3_q >= {1'b0, Prime, 1'b0}) begin
      res_q <= 30'(r3_q - {1'b0, Prime, 1'b0});
    end else if (r3_q >= {2'd0, Prime}) begin
      res_q <= 30'(r3_q - {2'd0, Prime});
    end else begin
      res_q <= r3_q[29:0];
    end
  end

  assign done_o = vld_q[3];
  assign res_o  = res_q;

endmodule

### design/lagr_ctrl.sv
// Sequencer for loads and evaluations: suffix pass, then per-node multiplies.
// Depends on lagr_pkg.
module lagr_ctrl
  import lagr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic         req_type_i,
  input  lagr_status_t status_i,
  output lagr_cmd_t    cmd_o,
  output logic         busy
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StSufGo   = 3'd1;
  localparam logic [2:0] StSufWait = 3'd2;
  localparam logic [2:0] StRead    = 3'd3;
  localparam logic [2:0] StMulGo   = 3'd4;
  localparam logic [2:0] StMulWait = 3'd5;
  localparam logic [2:0] StFinish  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.op = (state_q == StSufGo || state_q == StSufWait) ? OpSuf : step_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          if (req_type_i == ReqEval) begin
            cmd_o.eval_init = 1'b1;
            state_d = StSufGo;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      StSufGo: begin
        cmd_o.mul_go = 1'b1;
        state_d = StSufWait;
      end
      StSufWait: begin
        if (status_i.mul_done) begin
          if (status_i.k_zero) begin
            step_d  = OpYPre;
            state_d = StRead;
          end else begin
            state_d = StSufGo;
          end
        end
      end
      StRead: begin
        state_d = StMulGo;
      end
      StMulGo: begin
        cmd_o.mul_go = 1'b1;
        state_d = StMulWait;
      end
      StMulWait: begin
        if (status_i.mul_done) begin
          if (step_q == OpPre) begin
            step_d  = OpYPre;
            state_d = status_i.k_is_d ? StFinish : StRead;
          end else begin
            step_d  = step_q + 3'd1;
            state_d = StMulGo;
          end
        end
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= OpYPre;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

### design/lagr_datapath.sv
// Datapath: config registers, sample and suffix stores, inverse factorial
// ROM, running products and accumulator. Depends on lagr_pkg, lagr_modmul.
module lagr_datapath
  import lagr_pkg::*;
#(
  parameter int unsigned MaxNodes = MaxNodesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lagr_cmd_t    cmd_i,
  input  req_t         req_i,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [29:0]  cfg_data_i,
  output lagr_status_t status_o,
  output logic         done_o,
  output result_t      result_o
);

  localparam int unsigned AW = $clog2(MaxNodes);
  localparam int unsigned KW = $clog2(MaxNodes + 1);

  typedef logic [29:0] inv_tbl_t [MaxNodes];

  function automatic inv_tbl_t build_inv_tbl();
    inv_tbl_t        t;
    longint unsigned f;
    f = 1;
    for (int unsigned i = 0; i < MaxNodes; i++) begin
      if (i != 0) f = mulm_c(f, longint'(i) % Prime);
      t[i] = 30'(powm_c(f, longint'(Prime) - 2));
    end
    return t;
  endfunction

  localparam inv_tbl_t InvFact = build_inv_tbl();

  logic [29:0] base_q;
  logic [9:0]  degree_q;
  logic [KW-1:0] cnt_q;
  logic        after_eval_q;

  logic [29:0] sample_mem [MaxNodes];
  logic [29:0] suf_mem [MaxNodes + 1];

  logic [29:0] c_q, s_q, pre_q, t_q, acc_q;
  logic [AW-1:0] d_q;
  logic [KW-1:0] k_q;
  logic        short_q;
  logic [29:0] y_rd_q, suf_rd_q, invk_rd_q, invdk_rd_q;
  logic        done_q;
  result_t     result_q;

  logic [AW-1:0] d_sat;
  logic [KW-1:0] eff_cnt;
  logic [29:0] v_red, b_red;
  logic [30:0] diff_sum;
  logic [29:0] diff;
  logic [29:0] mul_a, mul_b, mul_res;
  logic        mul_done;
  logic [29:0] term;
  logic [30:0] acc_sum;
  logic [29:0] acc_next;
  logic [KW-1:0] suf_rd_idx;
  logic [AW-1:0] dk_idx;

  // Saturate degree to store capacity
  always_comb begin
    if (int'(degree_q) > int'(MaxNodes) - 1) begin
      d_sat = AW'(MaxNodes - 1);
    end else begin
      d_sat = AW'(degree_q);
    end
  end

  assign eff_cnt = after_eval_q ? '0 : cnt_q;
  assign v_red   = red30(req_i.eval_point);
  assign b_red   = red30(base_q);

  // Difference v - node k = c + k, reduced once
  assign diff_sum = {1'b0, c_q} + 31'(k_q);
  assign diff     = (diff_sum >= {1'b0, Prime}) ? 30'(diff_sum - {1'b0, Prime})
                                                : diff_sum[29:0];

  // Select multiplier operands
  always_comb begin
    case (cmd_i.op)
      OpSuf:    begin mul_a = s_q;   mul_b = diff;       end
      OpYPre:   begin mul_a = y_rd_q; mul_b = pre_q;     end
      OpTSuf:   begin mul_a = t_q;   mul_b = suf_rd_q;   end
      OpTInvK:  begin mul_a = t_q;   mul_b = invk_rd_q;  end
      OpTInvDk: begin mul_a = t_q;   mul_b = invdk_rd_q; end
      OpPre:    begin mul_a = pre_q; mul_b = diff;       end
      default:  begin mul_a = '0;    mul_b = '0;         end
    endcase
  end

  lagr_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // Signed accumulation of one term
  assign term     = (k_q[0] && mul_res != '0) ? (Prime - mul_res) : mul_res;
  assign acc_sum  = {1'b0, acc_q} + {1'b0, term};
  assign acc_next = (acc_sum >= {1'b0, Prime}) ? 30'(acc_sum - {1'b0, Prime})
                                               : acc_sum[29:0];

  // Config and load bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      degree_q     <= 10'd2;
      cnt_q        <= '0;
      after_eval_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgNodeBase: base_q   <= cfg_data_i;
          CfgDegree:   degree_q <= cfg_data_i[9:0];
          default:     base_q   <= base_q;
        endcase
      end
      if (cmd_i.load) begin
        after_eval_q <= 1'b0;
        if (int'(eff_cnt) < int'(MaxNodes)) begin
          cnt_q <= eff_cnt + KW'(1);
        end else begin
          cnt_q <= eff_cnt;
        end
      end
      if (cmd_i.eval_init) begin
        after_eval_q <= 1'b1;
      end
    end
  end

  // Sample store: write on load, read at k
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && int'(eff_cnt) < int'(MaxNodes)) begin
      sample_mem[eff_cnt[AW-1:0]] <= red30(req_i.sample_value);
    end
    y_rd_q <= sample_mem[k_q[AW-1:0]];
  end

  // Suffix store: seed at d+1, fill during the suffix pass, read at k+1
  assign suf_rd_idx = k_q + KW'(1);
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_init) begin
      suf_mem[KW'(d_sat) + KW'(1)] <= 30'd1;
    end else if (mul_done && cmd_i.op == OpSuf) begin
      suf_mem[k_q] <= mul_res;
    end
    suf_rd_q <= suf_mem[suf_rd_idx];
  end

  // Inverse factorial ROM reads
  assign dk_idx = d_q - k_q[AW-1:0];
  always_ff @(posedge clk_i) begin
    invk_rd_q  <= InvFact[k_q[AW-1:0]];
    invdk_rd_q <= InvFact[dk_idx];
  end

  // Evaluation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.eval_init) begin
      k_q <= KW'(d_sat);
    end else if (mul_done && cmd_i.op == OpSuf && k_q != '0) begin
      k_q <= k_q - KW'(1);
    end else if (mul_done && cmd_i.op == OpPre) begin
      k_q <= k_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_init) begin
      c_q     <= (v_red >= b_red) ? (v_red - b_red) : (v_red + (Prime - b_red));
      d_q     <= d_sat;
      short_q <= (cnt_q <= KW'(d_sat));
      s_q     <= 30'd1;
      pre_q   <= 30'd1;
      acc_q   <= '0;
    end else if (mul_done) begin
      case (cmd_i.op)
        OpSuf:    s_q   <= mul_res;
        OpYPre:   t_q   <= mul_res;
        OpTSuf:   t_q   <= mul_res;
        OpTInvK:  t_q   <= mul_res;
        OpTInvDk: acc_q <= acc_next;
        OpPre:    pre_q <= mul_res;
        default:  t_q   <= t_q;
      endcase
    end
    if (cmd_i.finish) begin
      result_q.interp_value  <= acc_q;
      result_q.samples_short <= short_q;
    end
  end

  assign status_o.k_zero   = (k_q == '0);
  assign status_o.k_is_d   = (k_q == KW'(d_q));
  assign status_o.mul_done = mul_done;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### design/lagrange_interp_consecutive_nodes_unit.sv
// Top level of the modular Lagrange interpolation unit (consecutive nodes).
// Depends on lagr_pkg, lagr_ctrl, lagr_datapath, assert_macros.svh.
//
//  channel  | handshake                     | payload
//  request  | start / busy                  | req_i (req_t)
//  result   | done_o strobe, one cycle      | result_o (result_t)
//  config   | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// A load is taken without leaving idle; busy stays low. An evaluation of
// degree D runs each multiply on the four-stage multiplier, which is the
// single shared unit, and waits for its result before the next one.
// A suffix pass walks the nodes from D down to 0, then each node reads its
// operands in the read state and runs five multiplies. Reset clears control
// and the node base and sets the degree to 2; the stores need no clearing.
// The receiver cannot stall; the strobe comes in the first cycle with busy low.
`include "assert_macros.svh"
module lagrange_interp_consecutive_nodes_unit
  import lagr_pkg::*;
#(
  parameter int unsigned MaxNodes = MaxNodesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output result_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [29:0] cfg_data_i
);

  lagr_cmd_t    cmd;
  lagr_status_t status;
  logic         accept;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  lagr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  lagr_datapath #(
    .MaxNodes (MaxNodes)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // Checks
  `ASSERT_IMPLIES(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `ASSERT_NEXT(a_eval_busy, clk_i, rst_ni, accept && req_i.req_type == ReqEval, busy)
  `ASSERT_IMPLIES(a_result_range, clk_i, rst_ni, done_o, result_o.interp_value < Prime)

endmodule
